// ===== rtl/sfvg_pkg.sv =====
// Package for the stroke font vector generator.
// Holds the sizes, coordinate types, control struct, the step conversion and the saturating add.
// No dependencies.
package sfvg_pkg;

    localparam int FONT_WORDS      = 4096;
    localparam int MAX_STROKES     = 64;
    localparam int COORD_BITS      = 20;

    localparam int ADDR_W          = $clog2(FONT_WORDS);
    localparam int CNT_W           = $clog2(MAX_STROKES + 1);
    localparam int WORD_W          = 32;
    // Wide enough for a 32-bit index plus the stroke table offset and count.
    localparam int SADDR_W         = WORD_W + 1;
    localparam int DELTA_W         = 13;

    localparam int CHR_TABLE_WORDS = 96;
    localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
    localparam logic [7:0] LAST_PRINTABLE  = 8'h7E;
    localparam logic [7:0] SUBST_CHAR      = 8'h2E;
    localparam logic [7:0] OP_NEW_STRIP    = 8'd5;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    localparam logic CFG_TEXT_PATH    = 1'b0;
    localparam logic CFG_CHAR_ADVANCE = 1'b1;

    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    localparam logic [9:0] CHAR_ADVANCE_RESET = 10'd92;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DELTA_W-1:0]    t_delta;

    // Control from the sequencer to the coordinate unit.
    typedef struct packed {
        logic   pen_load;   // start of a draw: pen takes the origin
        logic   restart;    // origin cleared at the start of a draw
        logic   step;       // pen moves by dx, dy
        logic   advance;    // origin moves along the text path
        t_delta dx;
        t_delta dy;
    } t_coord_ctl;

    // Sign-magnitude 12-bit step to a signed two's complement delta.
    function automatic t_delta sm12(input logic [11:0] f);
        t_delta mag;
        mag = {2'b00, f[10:0]};
        return f[11] ? -mag : mag;
    endfunction

    // Add a delta to a coordinate and clamp to the signed coordinate range.
    function automatic t_coord sat_add(input t_coord a, input t_delta d);
        logic signed [COORD_BITS:0] s;
        s = {a[COORD_BITS-1], a} + {{(COORD_BITS + 1 - DELTA_W){d[DELTA_W-1]}}, d};
        if (s[COORD_BITS] != s[COORD_BITS-1]) begin
            return s[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                 : {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return s[COORD_BITS-1:0];
    endfunction

endpackage

// ===== rtl/sfvg_req_if.sv =====
// Request channel of the stroke font vector generator: font loads and draws.
// Has no dependencies; the word address is written out as 12 bits.
interface sfvg_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [11:0] word_address;
    logic [31:0] word_data;
    logic [7:0]  char_code;
    logic        restart;

    modport source (output valid, req_type, word_address, word_data, char_code, restart,
                    input ready);
    modport sink   (input valid, req_type, word_address, word_data, char_code, restart,
                    output ready);
endinterface

// ===== rtl/sfvg_vtx_if.sv =====
// Vertex channel of the stroke font vector generator.
// Depends on sfvg_pkg for the coordinate type.
interface sfvg_vtx_if;
    logic           valid;
    logic           ready;
    sfvg_pkg::t_coord vertex_x;
    sfvg_pkg::t_coord vertex_y;
    logic           new_strip;
    logic           has_vertex;
    logic           last;

    modport source (output valid, vertex_x, vertex_y, new_strip, has_vertex, last,
                    input ready);
    modport sink   (input valid, vertex_x, vertex_y, new_strip, has_vertex, last,
                    output ready);
endinterface

// ===== rtl/sfvg_coord_unit.sv =====
// Pen and character origin registers with saturating arithmetic.
// Depends on sfvg_pkg for the coordinate types and control struct.
module sfvg_coord_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfvg_pkg::t_coord_ctl i_ctl,
    input  logic [1:0]          i_text_path,
    input  logic [9:0]          i_char_advance,
    output sfvg_pkg::t_coord    o_next_x,
    output sfvg_pkg::t_coord    o_next_y
);
    import sfvg_pkg::*;

    t_coord r_org_x, r_org_y;
    t_coord r_pen_x, r_pen_y;
    t_delta adv_pos, adv_neg;

    // Pen position after the current stroke step.
    assign o_next_x = sat_add(r_pen_x, i_ctl.dx);
    assign o_next_y = sat_add(r_pen_y, i_ctl.dy);

    assign adv_pos = {3'b000, i_char_advance};
    assign adv_neg = -adv_pos;

    // Origin: cleared on restart, moved along the text path after a character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
        end else if (i_ctl.restart) begin
            r_org_x <= '0;
            r_org_y <= '0;
        end else if (i_ctl.advance) begin
            unique case (i_text_path)
                DIR_RIGHT: r_org_x <= sat_add(r_org_x, adv_pos);
                DIR_LEFT:  r_org_x <= sat_add(r_org_x, adv_neg);
                DIR_UP:    r_org_y <= sat_add(r_org_y, adv_pos);
                DIR_DOWN:  r_org_y <= sat_add(r_org_y, adv_neg);
                default:   r_org_x <= r_org_x;
            endcase
        end
    end

    // Pen: starts at the origin, then follows the strokes.
    always_ff @(posedge i_clk) begin
        if (i_ctl.pen_load) begin
            r_pen_x <= i_ctl.restart ? '0 : r_org_x;
            r_pen_y <= i_ctl.restart ? '0 : r_org_y;
        end else if (i_ctl.step) begin
            r_pen_x <= o_next_x;
            r_pen_y <= o_next_y;
        end
    end

endmodule

// ===== rtl/stroke_font_vector_generator_unit.sv =====
// Top level of the stroke font vector generator: font memory, draw sequencer
// and vertex output register. Depends on sfvg_pkg, sfvg_req_if, sfvg_vtx_if
// and sfvg_coord_unit.
//
//  Channel  | Direction | Transfer
//  ---------+-----------+--------------------------------------------------
//  i_req    | in        | one font word load or one character draw
//  o_vtx    | out       | one vertex, or an empty end marker
//  i_cfg_*  | in        | register write (text path, character advance)
//
// A draw of N strokes (N at most MAX_STROKES), or of a strokeless character,
// makes two index reads and then one stroke word read per cycle, while the
// output is not stalled, from the single read port of the font memory.
// Reset clears the origin, the registers and the sequencer; the font memory
// is not cleared. A stalled output holds the sequencer, and a new request
// is taken while the last vertex of the previous one still waits.
module stroke_font_vector_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfvg_req_if.sink    i_req,
    sfvg_vtx_if.source  o_vtx,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    import sfvg_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_IDX0, S_IDX1, S_DATA, S_EMPTY} t_state;

    t_state                 r_state;
    logic [WORD_W-1:0]      r_mem [FONT_WORDS];
    logic [WORD_W-1:0]      r_rdata;
    logic [WORD_W-1:0]      r_first;
    logic [6:0]             r_idx1;
    logic [SADDR_W-1:0]     r_saddr;
    logic                   r_zero;
    logic                   r_first_k;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_out_valid;
    logic [1:0]             r_text_path;
    logic [9:0]             r_char_adv;

    logic                   accept, draw_acc, load_acc, slot_free;
    logic [7:0]             chr;
    logic [6:0]             idx0;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [SADDR_W-1:0]     sa_start;
    logic [WORD_W-1:0]      span;
    logic [CNT_W-1:0]       span_cnt;
    logic                   nonempty;
    logic [WORD_W-1:0]      word;
    logic                   last_stroke;
    t_coord_ctl             cctl;
    t_coord                 next_x, next_y;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_path <= DIR_RIGHT;
            r_char_adv  <= CHAR_ADVANCE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEXT_PATH:    r_text_path <= i_cfg_data[1:0];
                CFG_CHAR_ADVANCE: r_char_adv  <= i_cfg_data;
                default:          r_text_path <= r_text_path;
            endcase
        end
    end

    // Request handshake.
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign draw_acc    = accept && (i_req.req_type == REQ_DRAW);
    assign load_acc    = accept && (i_req.req_type == REQ_LOAD);
    assign slot_free   = !r_out_valid || o_vtx.ready;

    // Non-printable codes are drawn as a period.
    assign chr  = (i_req.char_code < FIRST_PRINTABLE || i_req.char_code > LAST_PRINTABLE)
                  ? SUBST_CHAR : i_req.char_code;
    assign idx0 = 7'(chr - FIRST_PRINTABLE);

    // Stroke bounds from the two index words.
    assign sa_start = {1'b0, r_first} + SADDR_W'(CHR_TABLE_WORDS - 1);
    assign nonempty = r_rdata > r_first;
    assign span     = r_rdata - r_first;
    assign span_cnt = (span > WORD_W'(MAX_STROKES)) ? CNT_W'(MAX_STROKES)
                                                    : span[CNT_W-1:0];

    // Stroke word, zero when its address lies beyond the memory.
    assign word        = r_zero ? '0 : r_rdata;
    assign last_stroke = (r_cnt == CNT_W'(1));

    // Memory read port selection.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(idx0);
        unique case (r_state)
            S_IDLE: begin
                rd_en   = draw_acc;
                rd_addr = ADDR_W'(idx0);
            end
            S_IDX0: begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(r_idx1);
            end
            S_IDX1: begin
                rd_en   = nonempty;
                rd_addr = sa_start[ADDR_W-1:0];
            end
            S_DATA: begin
                rd_en   = slot_free && !last_stroke;
                rd_addr = r_saddr[ADDR_W-1:0];
            end
            S_EMPTY: begin
                rd_en   = 1'b0;
            end
            default: rd_en = 1'b0;
        endcase
    end

    // Font memory: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (load_acc && (32'(i_req.word_address) < 32'(FONT_WORDS))) begin
            r_mem[ADDR_W'(i_req.word_address)] <= i_req.word_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Controls for the pen and origin.
    always_comb begin
        cctl.pen_load = draw_acc;
        cctl.restart  = draw_acc && i_req.restart;
        cctl.step     = (r_state == S_DATA) && slot_free;
        cctl.advance  = ((r_state == S_DATA) && slot_free && last_stroke)
                        || ((r_state == S_EMPTY) && slot_free);
        cctl.dx       = sm12(word[23:12]);
        cctl.dy       = sm12(word[11:0]);
    end

    sfvg_coord_unit u_coord (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (cctl),
        .i_text_path    (r_text_path),
        .i_char_advance (r_char_adv),
        .o_next_x       (next_x),
        .o_next_y       (next_y)
    );

    // Sequencer and vertex output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_vtx.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (draw_acc) begin
                        r_idx1  <= idx0 + 7'd1;
                        r_state <= S_IDX0;
                    end
                end
                S_IDX0: begin
                    r_first <= r_rdata;
                    r_state <= S_IDX1;
                end
                S_IDX1: begin
                    if (nonempty) begin
                        r_cnt     <= span_cnt;
                        r_saddr   <= sa_start + SADDR_W'(1);
                        r_zero    <= sa_start >= SADDR_W'(FONT_WORDS);
                        r_first_k <= 1'b1;
                        r_state   <= S_DATA;
                    end else begin
                        r_state <= S_EMPTY;
                    end
                end
                S_DATA: begin
                    if (slot_free) begin
                        r_out_valid      <= 1'b1;
                        o_vtx.vertex_x   <= next_x;
                        o_vtx.vertex_y   <= next_y;
                        o_vtx.new_strip  <= r_first_k || (word[31:24] == OP_NEW_STRIP);
                        o_vtx.has_vertex <= 1'b1;
                        o_vtx.last       <= last_stroke;
                        r_first_k        <= 1'b0;
                        r_cnt            <= r_cnt - CNT_W'(1);
                        if (last_stroke) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_saddr <= r_saddr + SADDR_W'(1);
                            r_zero  <= r_saddr >= SADDR_W'(FONT_WORDS);
                        end
                    end
                end
                S_EMPTY: begin
                    if (slot_free) begin
                        r_out_valid      <= 1'b1;
                        o_vtx.vertex_x   <= '0;
                        o_vtx.vertex_y   <= '0;
                        o_vtx.new_strip  <= 1'b0;
                        o_vtx.has_vertex <= 1'b0;
                        o_vtx.last       <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_vtx.valid = r_out_valid;

    // A draw transfer always starts the index reads.
    a_draw_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        draw_acc |=> (r_state == S_IDX0))
        else $error("draw transfer did not start the index reads");

    // The stroke count stays within the stroke limit while drawing.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> (r_cnt != '0 && r_cnt <= CNT_W'(MAX_STROKES)))
        else $error("stroke count out of range");

    // The final stroke marks its vertex as last and frees the request side.
    a_last_stroke: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DATA) && slot_free && last_stroke)
        |=> (r_state == S_IDLE && o_vtx.valid && o_vtx.last))
        else $error("final stroke not closed correctly");

    // An empty marker closes its character and starts no polyline.
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx.valid && !o_vtx.has_vertex) |-> (o_vtx.last && !o_vtx.new_strip))
        else $error("empty marker with wrong flags");

endmodule
